// ----- hdl/sbl_pkg.sv -----
// Shared types and constants for the Sobel magnitude / double threshold block.
// Depends on nothing; every other file but sbl_ram imports it.
package sbl_pkg;

  // Configuration register widths and indexes
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int THR_W        = 11;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_IDX_W    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THRESHOLD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD = 2'd3;

  localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 13'd480;
  localparam logic [THR_W-1:0]        RESET_LOW    = 11'd75;
  localparam logic [THR_W-1:0]        RESET_HIGH   = 11'd150;
  localparam int                      MIN_DIM      = 3;

  // Position in frame and last-pixel index (width * height - 1)
  localparam int LAST_W = WIDTH_REG_W + HEIGHT_REG_W;
  // Row counter; saturates, never wraps
  localparam int ROW_W  = 15;

  // Gray = floor(sum / 3) as (sum * 683) >> 11, exact for sums below 2048
  localparam int GRAY_W      = 8;
  localparam int SUM_W       = 10;
  localparam int GRAY_PROD_W = 20;
  localparam logic [GRAY_PROD_W-1:0] GRAY_RECIP = 20'd683;
  localparam int GRAY_SHIFT  = 11;

  // Gradient and magnitude
  localparam int GRAD_W   = 11;
  localparam int SQR_W    = 20;
  localparam int MAG_W    = 11;
  localparam int SQ_STEPS = MAG_W;
  localparam int RAD_W    = 2 * SQ_STEPS;
  localparam int REM_W    = MAG_W + 2;
  localparam logic [MAG_W-1:0] MAG_MAX = 11'd1442;

  // Edge classes
  localparam logic [1:0] CLASS_NONE   = 2'd0;
  localparam logic [1:0] CLASS_WEAK   = 2'd1;
  localparam logic [1:0] CLASS_STRONG = 2'd2;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [WIDTH_REG_W-1:0]  width;
    logic [HEIGHT_REG_W-1:0] height;
    logic [LAST_W-1:0]       last;
  } sbl_geom_t;

  typedef struct packed {
    logic [THR_W-1:0] low;
    logic [THR_W-1:0] high;
  } sbl_thr_t;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     frame_end;
  } sbl_grad_t;

endpackage

// ----- hdl/sbl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module sbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/sbl_front.sv -----
// Front end: pixel intake, gray conversion, line stores, 3x3 window, Sobel sums.
// Depends on sbl_pkg and sbl_ram; pushes gradient pairs into sbl_queue.
module sbl_front import sbl_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  sbl_geom_t         geom,
  input  logic              hold,
  input  logic [QCNT_W-1:0] q_count,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  input  logic              pad,
  output logic              push,
  output sbl_grad_t         push_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int CMP_W = 15;

  // Clear sweep over the line stores after reset
  logic             clr_active;
  logic [COL_W-1:0] clr_cnt;

  // Position state
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [LAST_W-1:0] pos;
  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;
  logic [LAST_W-1:0] pos_next;

  // Second stage, line store data arrives here
  logic             s1_valid;
  logic [COL_W-1:0] s1_col;
  logic [GRAY_W-1:0] s1_gray;
  logic             s1_emit;
  logic             s1_inner;
  logic             s1_fend;

  logic [GRAY_W-1:0] win [9];
  logic [GRAY_W-1:0] win_next [9];
  logic [GRAY_W-1:0] up_rd;
  logic [GRAY_W-1:0] mid_rd;

  logic              accept;
  logic [SUM_W-1:0]  sum;
  logic [GRAY_PROD_W-1:0] gray_prod;
  logic [GRAY_W-1:0] gray;
  logic [CMP_W-1:0]  col_x;
  logic [CMP_W-1:0]  col_inc;
  logic [CMP_W-1:0]  w_x;
  logic [CMP_W-1:0]  ccol_x;
  logic [ROW_W-1:0]  crow;
  logic [ROW_W-1:0]  h_x;
  logic              wrap;
  logic              emit;
  logic              inner;
  logic              fend;
  logic [QCNT_W:0]   q_need;
  logic              ram_we;
  logic [COL_W-1:0]  ram_waddr;
  logic [GRAY_W-1:0] up_wdata;
  logic [GRAY_W-1:0] mid_wdata;
  logic signed [GRAD_W:0] gx;
  logic signed [GRAD_W:0] gy;

  // Admission: room in the queue for the pending push and this item
  always_comb begin
    q_need   = {1'b0, q_count} + (QCNT_W+1)'(s1_valid && s1_emit) + (QCNT_W+1)'(1);
    in_stall = clr_active || hold || (q_need > (QCNT_W+1)'(QUEUE_DEPTH));
    accept   = in_valid && !in_stall;
  end

  always_comb begin
    sum       = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
    gray_prod = GRAY_PROD_W'(sum) * GRAY_RECIP;
    gray      = pad ? '0 : GRAY_W'(gray_prod >> GRAY_SHIFT);
  end

  // Classify the item: does it emit, and is its center pixel an inner one
  always_comb begin
    col_x   = CMP_W'(col);
    col_inc = col_x + CMP_W'(1);
    w_x     = CMP_W'(geom.width);
    h_x     = ROW_W'(geom.height);
    wrap    = col_inc >= w_x;
    emit    = (row >= ROW_W'(2)) || (row == ROW_W'(1) && col != '0);
    if (col != '0) begin
      crow   = row - ROW_W'(1);
      ccol_x = col_x - CMP_W'(1);
    end else begin
      crow   = row - ROW_W'(2);
      ccol_x = w_x - CMP_W'(1);
    end
    inner = (crow != '0) && (crow < h_x - ROW_W'(1)) &&
            (ccol_x != '0) && (ccol_x < w_x - CMP_W'(1));
    fend  = emit && (pos >= geom.last);

    if (wrap) begin
      col_next = '0;
      row_next = (row == '1) ? row : row + ROW_W'(1);
    end else begin
      col_next = COL_W'(col_inc);
      row_next = row;
    end
    pos_next = pos;
    if (emit) begin
      if (fend) begin
        col_next = '0;
        row_next = '0;
        pos_next = '0;
      end else begin
        pos_next = pos + LAST_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_cnt    <= '0;
      col        <= '0;
      row        <= '0;
      pos        <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (clr_active) begin
        if (clr_cnt == COL_W'(MAX_WIDTH - 1)) begin
          clr_active <= 1'b0;
        end
        clr_cnt <= clr_cnt + COL_W'(1);
      end
      s1_valid <= accept;
      if (accept) begin
        col <= col_next;
        row <= row_next;
        pos <= pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= col;
      s1_gray  <= gray;
      s1_emit  <= emit;
      s1_inner <= inner;
      s1_fend  <= fend;
    end
  end

  // Line stores: shift the column down one row, write back in the second stage
  always_comb begin
    ram_we    = clr_active || s1_valid;
    ram_waddr = clr_active ? clr_cnt : s1_col;
    up_wdata  = clr_active ? '0 : mid_rd;
    mid_wdata = clr_active ? '0 : s1_gray;
  end

  sbl_ram #(
    .WIDTH (GRAY_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (up_wdata),
    .re    (accept),
    .raddr (col),
    .rdata (up_rd)
  );

  sbl_ram #(
    .WIDTH (GRAY_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (mid_wdata),
    .re    (accept),
    .raddr (col),
    .rdata (mid_rd)
  );

  // Window: shift left, insert the new column on the right
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_next[r*3]     = win[r*3+1];
      win_next[r*3 + 1] = win[r*3+2];
    end
    win_next[2] = up_rd;
    win_next[5] = mid_rd;
    win_next[8] = s1_gray;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (s1_valid) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

  always_comb begin
    gx = - $signed({4'b0, win_next[0]}) + $signed({4'b0, win_next[2]})
         - ($signed({4'b0, win_next[3]}) <<< 1) + ($signed({4'b0, win_next[5]}) <<< 1)
         - $signed({4'b0, win_next[6]}) + $signed({4'b0, win_next[8]});
    gy = - $signed({4'b0, win_next[0]}) - ($signed({4'b0, win_next[1]}) <<< 1)
         - $signed({4'b0, win_next[2]}) + $signed({4'b0, win_next[6]})
         + ($signed({4'b0, win_next[7]}) <<< 1) + $signed({4'b0, win_next[8]});
    push                = s1_valid && s1_emit;
    push_data.gx        = s1_inner ? GRAD_W'(gx) : '0;
    push_data.gy        = s1_inner ? GRAD_W'(gy) : '0;
    push_data.frame_end = s1_fend;
  end

endmodule

// ----- hdl/sbl_queue.sv -----
// Short queue of gradient pairs between the front and back ends.
// Depends on sbl_pkg.
module sbl_queue import sbl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sbl_grad_t         push_data,
  input  logic              pop,
  output sbl_grad_t         pop_data,
  output logic [QCNT_W-1:0] count
);

  sbl_grad_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- hdl/sbl_back.sv -----
// Back end: squares, digit-by-digit square root pipeline, threshold, output register.
// Depends on sbl_pkg; pops gradient pairs from sbl_queue.
module sbl_back import sbl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  sbl_thr_t          thr,
  input  logic [QCNT_W-1:0] q_count,
  input  sbl_grad_t         pop_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        edge_class,
  output logic [MAG_W-1:0]  magnitude,
  output logic              frame_end
);

  logic adv;

  // Square stage
  logic              m_valid;
  logic [SQR_W-1:0]  m_gx2;
  logic [SQR_W-1:0]  m_gy2;
  logic              m_fend;
  logic signed [2*GRAD_W-1:0] gx2_full;
  logic signed [2*GRAD_W-1:0] gy2_full;

  // Root stages, index 0 holds the radicand
  logic              v    [SQ_STEPS+1];
  logic [RAD_W-1:0]  x    [SQ_STEPS+1];
  logic [REM_W-1:0]  rem  [SQ_STEPS+1];
  logic [MAG_W-1:0]  root [SQ_STEPS+1];
  logic              fe   [SQ_STEPS+1];
  logic [REM_W-1:0]  rem_next  [SQ_STEPS+1];
  logic [MAG_W-1:0]  root_next [SQ_STEPS+1];

  logic [1:0]        cls;

  // The whole back end advances together unless the output is held
  assign adv = !out_valid || !out_stall;
  assign pop = adv && (q_count != '0);

  always_comb begin
    gx2_full = pop_data.gx * pop_data.gx;
    gy2_full = pop_data.gy * pop_data.gy;
  end

  always_comb begin
    rem_next[0]  = '0;
    root_next[0] = '0;
    for (int k = 1; k <= SQ_STEPS; k++) begin
      logic [REM_W+1:0] r2;
      logic [REM_W+1:0] t;
      r2 = {rem[k-1], x[k-1][RAD_W-1 -: 2]};
      t  = {2'b00, root[k-1], 2'b01};
      if (r2 >= t) begin
        rem_next[k]  = REM_W'(r2 - t);
        root_next[k] = {root[k-1][MAG_W-2:0], 1'b1};
      end else begin
        rem_next[k]  = REM_W'(r2);
        root_next[k] = {root[k-1][MAG_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      for (int k = 0; k <= SQ_STEPS; k++) begin
        v[k] <= 1'b0;
      end
    end else if (adv) begin
      m_valid <= pop;
      v[0]    <= m_valid;
      for (int k = 1; k <= SQ_STEPS; k++) begin
        v[k] <= v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_gx2   <= SQR_W'(gx2_full);
      m_gy2   <= SQR_W'(gy2_full);
      m_fend  <= pop_data.frame_end;
      x[0]    <= RAD_W'(m_gx2) + RAD_W'(m_gy2);
      rem[0]  <= '0;
      root[0] <= '0;
      fe[0]   <= m_fend;
      for (int k = 1; k <= SQ_STEPS; k++) begin
        x[k]    <= x[k-1] << 2;
        rem[k]  <= rem_next[k];
        root[k] <= root_next[k];
        fe[k]   <= fe[k-1];
      end
    end
  end

  always_comb begin
    if (root[SQ_STEPS] > thr.high) begin
      cls = CLASS_STRONG;
    end else if (root[SQ_STEPS] > thr.low) begin
      cls = CLASS_WEAK;
    end else begin
      cls = CLASS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      magnitude  <= root[SQ_STEPS];
      edge_class <= cls;
      frame_end  <= fe[SQ_STEPS];
    end
  end

endmodule

// ----- hdl/sobel_magnitude_double_threshold.sv -----
// Top level of the Sobel gradient magnitude block with double threshold.
// Depends on sbl_pkg, sbl_front, sbl_queue and sbl_back (sbl_front uses sbl_ram).
//
//   channel   handshake             payload
//   -------   -------------------   ------------------------------------------
//   input     in_valid / in_stall   red, green, blue, pad
//   output    out_valid / out_stall edge_class, magnitude, frame_end
//   config    cfg_write             cfg_index, cfg_data (no wait, no read-back)
//
// One pixel per clock in steady state; the line stores (one write and one read
// port each) and the 11-stage square root pipeline both take a new item every cycle.
// An accepted pixel passes the second stage and the queue, then the square stage,
// the radicand register, the root steps and the output register. After reset the
// line stores are swept to zero, one column a cycle, while in_stall stays high.
// in_stall also rises for one cycle after each configuration write, and whenever
// the 4-entry queue could not take what is in flight; out_stall freezes the back end.
module sobel_magnitude_double_threshold import sbl_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            red,
  input  logic [7:0]            green,
  input  logic [7:0]            blue,
  input  logic                  pad,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            edge_class,
  output logic [MAG_W-1:0]      magnitude,
  output logic                  frame_end
);

  // Configuration registers
  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [THR_W-1:0]        low_threshold;
  logic [THR_W-1:0]        high_threshold;
  logic                    cfg_hold;

  // Clamped geometry and last pixel index
  logic [WIDTH_REG_W-1:0]  w_eff;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic [LAST_W-1:0]       area;
  logic [LAST_W-1:0]       last;
  sbl_geom_t               geom;
  sbl_thr_t                thr;

  logic              push;
  sbl_grad_t         push_data;
  logic              pop;
  sbl_grad_t         pop_data;
  logic [QCNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RESET_WIDTH;
      image_height   <= RESET_HEIGHT;
      low_threshold  <= RESET_LOW;
      high_threshold <= RESET_HIGH;
      cfg_hold       <= 1'b0;
    end else begin
      // hold input for a cycle so the registered frame size catches up
      cfg_hold <= cfg_write;
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:    image_width    <= cfg_data[WIDTH_REG_W-1:0];
          REG_IMAGE_HEIGHT:   image_height   <= cfg_data[HEIGHT_REG_W-1:0];
          REG_LOW_THRESHOLD:  low_threshold  <= cfg_data[THR_W-1:0];
          REG_HIGH_THRESHOLD: high_threshold <= cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Clamp the geometry into [3, MAX]
  always_comb begin
    if (32'(image_width) < 32'(MIN_DIM)) begin
      w_eff = WIDTH_REG_W'(MIN_DIM);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = WIDTH_REG_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (32'(image_height) < 32'(MIN_DIM)) begin
      h_eff = HEIGHT_REG_W'(MIN_DIM);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h_eff = HEIGHT_REG_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
    area = LAST_W'(w_eff) * LAST_W'(h_eff);
  end

  // Registered every cycle; valid well before the reset sweep ends
  always_ff @(posedge clk) begin
    last <= area - LAST_W'(1);
  end

  always_comb begin
    geom.width  = w_eff;
    geom.height = h_eff;
    geom.last   = last;
    thr.low     = low_threshold;
    thr.high    = high_threshold;
  end

  sbl_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .geom      (geom),
    .hold      (cfg_hold),
    .q_count   (q_count),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .pad       (pad),
    .push      (push),
    .push_data (push_data)
  );

  sbl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .count     (q_count)
  );

  sbl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .thr        (thr),
    .q_count    (q_count),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .edge_class (edge_class),
    .magnitude  (magnitude),
    .frame_end  (frame_end)
  );

endmodule

// ----- hdl/sbl_checker.sv -----
// Port-level checks for the Sobel magnitude block, bound to the top level.
// Depends on sbl_pkg and sobel_magnitude_double_threshold.
module sbl_checker import sbl_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_write,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [1:0]            edge_class,
  input logic [MAG_W-1:0]      magnitude,
  input logic                  frame_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(magnitude) &&
      $stable(edge_class) && $stable(frame_end))
    else $error("output transfer changed while stalled");

  a_mag_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> magnitude <= MAG_MAX)
    else $error("magnitude beyond largest Sobel response");

  a_zero_none: assert property (@(posedge clk) disable iff (rst)
    out_valid && magnitude == '0 |-> edge_class == CLASS_NONE)
    else $error("zero magnitude classified as an edge");

  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    cfg_write |=> in_stall)
    else $error("input taken right after a configuration write");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_stall)
    else $error("block not quiet after reset");

endmodule

bind sobel_magnitude_double_threshold sbl_checker u_sbl_checker (.*);

// ----- tb/sv/sobel_edge_check_pkg.sv -----
`timescale 1ns / 100ps
// Pixel-accurate predictor and result checker for the Sobel edge block.
// Depends on sbl_pkg for field widths, register indexes and edge class codes.
package sobel_edge_check_pkg;
  import sbl_pkg::*;

  localparam int LINE_MAX  = 1024;
  localparam int ROWS_MAX  = 4096;
  localparam int PRINT_CAP = 100;

  typedef struct packed {
    logic [1:0]       edge_class;
    logic [MAG_W-1:0] magnitude;
    logic             frame_end;
  } edge_result_t;

  class sobel_edge_checker;
    logic [GRAY_W-1:0]       upper_line [LINE_MAX];
    logic [GRAY_W-1:0]       middle_line [LINE_MAX];
    logic [GRAY_W-1:0]       window [9];
    int unsigned             next_col;
    int unsigned             next_row;
    int unsigned             result_pos;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [THR_W-1:0]        low_thr;
    logic [THR_W-1:0]        high_thr;
    edge_result_t            expected_edges [$];
    int unsigned             mismatches;
    int unsigned             results_checked;
    int unsigned             frames_closed;
    int unsigned             class_hits [3];

    function new();
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      foreach (class_hits[i]) class_hits[i] = 0;
      next_col        = 0;
      next_row        = 0;
      result_pos      = 0;
      width_reg       = RESET_WIDTH;
      height_reg      = RESET_HEIGHT;
      low_thr         = RESET_LOW;
      high_thr        = RESET_HIGH;
      mismatches      = 0;
      results_checked = 0;
      frames_closed   = 0;
    endfunction

    function int unsigned fit_dim(int unsigned v, int unsigned hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned eff_width();
      return fit_dim(width_reg, LINE_MAX);
    endfunction

    function int unsigned eff_height();
      return fit_dim(height_reg, ROWS_MAX);
    endfunction

    function int unsigned pending();
      return expected_edges.size();
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_IMAGE_WIDTH:    width_reg  = val[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT:   height_reg = val[HEIGHT_REG_W-1:0];
        REG_LOW_THRESHOLD:  low_thr    = val[THR_W-1:0];
        REG_HIGH_THRESHOLD: high_thr   = val[THR_W-1:0];
        default: ;
      endcase
    endfunction

    // Bit-serial floor square root; the magnitude never needs more than 11 bits.
    function int unsigned floor_root(int unsigned v);
      int unsigned root;
      int unsigned trial;
      root = 0;
      for (int b = MAG_W - 1; b >= 0; b--) begin
        trial = root | (1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    // Advance the window and line stores by one transfer and queue its result, if any.
    function void take_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic p);
      int unsigned  w, h, col, row, gray, crow, ccol, last, mag;
      int           gx, gy;
      bit           emit;
      edge_result_t res;
      w    = eff_width();
      h    = eff_height();
      col  = next_col % LINE_MAX;
      row  = next_row;
      gray = p ? 0 : (int'(r) + int'(g) + int'(b)) / 3;
      for (int k = 0; k < 3; k++) begin
        window[k*3]   = window[k*3+1];
        window[k*3+1] = window[k*3+2];
      end
      window[2]        = upper_line[col];
      window[5]        = middle_line[col];
      window[8]        = 8'(gray);
      upper_line[col]  = middle_line[col];
      middle_line[col] = 8'(gray);

      emit = (row >= 2) || (row == 1 && col >= 1);
      if (col + 1 >= w) begin
        next_col = 0;
        next_row = next_row + 1;
      end else begin
        next_col = col + 1;
      end
      if (!emit) return;

      last = w * h - 1;
      if (col >= 1) begin
        crow = row - 1;
        ccol = col - 1;
      end else begin
        crow = row - 2;
        ccol = w - 1;
      end
      mag = 0;
      if (crow != 0 && crow < h - 1 && ccol != 0 && ccol < w - 1) begin
        gx = int'(window[2]) - int'(window[0]) + 2 * (int'(window[5]) - int'(window[3]))
             + int'(window[8]) - int'(window[6]);
        gy = int'(window[6]) - int'(window[0]) + 2 * (int'(window[7]) - int'(window[1]))
             + int'(window[8]) - int'(window[2]);
        mag = floor_root(gx * gx + gy * gy);
      end
      if (mag > high_thr)     res.edge_class = CLASS_STRONG;
      else if (mag > low_thr) res.edge_class = CLASS_WEAK;
      else                    res.edge_class = CLASS_NONE;
      res.magnitude = MAG_W'(mag);
      if (result_pos >= last) begin
        res.frame_end = 1'b1;
        next_col      = 0;
        next_row      = 0;
        result_pos    = 0;
      end else begin
        res.frame_end = 1'b0;
        result_pos    = result_pos + 1;
      end
      expected_edges.push_back(res);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("mismatch: %s", msg);
    endtask

    task check_edge(logic [1:0] cls, logic [MAG_W-1:0] mag, logic fe);
      edge_result_t want;
      if (expected_edges.size() == 0) begin
        report_mismatch($sformatf("unexpected result class %0d magnitude %0d frame_end %0b",
                                  cls, mag, fe));
        return;
      end
      want = expected_edges.pop_front();
      if (cls !== want.edge_class || mag !== want.magnitude || fe !== want.frame_end)
        report_mismatch($sformatf(
          "result %0d: got class %0d mag %0d end %0b, want class %0d mag %0d end %0b",
          results_checked, cls, mag, fe, want.edge_class, want.magnitude, want.frame_end));
      results_checked++;
      class_hits[want.edge_class]++;
      if (want.frame_end) frames_closed++;
    endtask
  endclass

endpackage

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// Top-level testbench for sobel_magnitude_double_threshold: drives pixels and register writes,
// checks every result against sobel_edge_check_pkg. Depends on sbl_pkg and the block's RTL.
module tb_top;
  import sbl_pkg::*;
  import sobel_edge_check_pkg::*;

  // Quiet-cycle limit: reset + line store clearing + pressure hold + settling
  // pauses, taken several times over.
  localparam int WATCHDOG_LIMIT = 6000;
  // Room for a pixel to reach the output register, plus room for the queue.
  localparam int SETTLE_CYCLES  = 48;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 120;

  typedef enum int {TEXTURE_NOISE, TEXTURE_BINARY, TEXTURE_FLAT, TEXTURE_STEP} texture_t;
  typedef enum int {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            red;
  logic [7:0]            green;
  logic [7:0]            blue;
  logic                  pad;
  logic                  out_valid;
  logic                  out_stall;
  logic [1:0]            edge_class;
  logic [MAG_W-1:0]      magnitude;
  logic                  frame_end;

  sobel_edge_checker chk;
  int unsigned       tx_idle_pct;
  int unsigned       rx_idle_pct;
  bit                hold_req;
  int unsigned       pixels_sent;
  int unsigned       reg_writes;

  sobel_magnitude_double_threshold u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .pad        (pad),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .edge_class (edge_class),
    .magnitude  (magnitude),
    .frame_end  (frame_end)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one pixel, idling first at the current rate, and hold it until the
  // transfer happens. Valid stays high afterwards; the caller lowers it.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic p);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    red      <= r;
    green    <= g;
    blue     <= b;
    pad      <= p;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    chk.take_pixel(r, g, b, p);
    pixels_sent++;
  endtask

  // Drop valid, wait until every expected result has been taken, then give the
  // pipeline time to empty of items that produce no result.
  task automatic settle();
    in_valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leave cfg_write high across back-to-back writes; apply_setup lowers it once.
  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(posedge clk);
    chk.load_reg(idx, CFG_DATA_W'(val));
    reg_writes++;
  endtask

  // Write the registers whose value is not negative, once the block is idle.
  task automatic apply_setup(input int w, input int h, input int lo, input int hi);
    settle();
    if (w >= 0)  write_one(REG_IMAGE_WIDTH, w);
    if (h >= 0)  write_one(REG_IMAGE_HEIGHT, h);
    if (lo >= 0) write_one(REG_LOW_THRESHOLD, lo);
    if (hi >= 0) write_one(REG_HIGH_THRESHOLD, hi);
    cfg_write <= 1'b0;
  endtask

  function automatic int pick_threshold();
    case ($urandom_range(9))
      0:       return 0;
      1:       return 2047;
      2:       return $urandom_range(2047);
      default: return $urandom_range(350);
    endcase
  endfunction

  // Pick a random geometry and threshold pair; leave some registers as they are.
  // Now and then set the cfg_data bits above an 11-bit register.
  task automatic random_setup();
    int w, h, lo, hi, t;
    case ($urandom_range(9))
      0:       w = $urandom_range(2);
      1:       w = $urandom_range(24, 13);
      default: w = $urandom_range(12, 3);
    endcase
    case ($urandom_range(9))
      0:       h = $urandom_range(2);
      1:       h = $urandom_range(10, 7);
      default: h = $urandom_range(6, 3);
    endcase
    lo = pick_threshold();
    hi = pick_threshold();
    if (lo > hi && $urandom_range(4) != 0) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    if ($urandom_range(9) == 0) w  = w  | ($urandom_range(3) << WIDTH_REG_W);
    if ($urandom_range(9) == 0) lo = lo | ($urandom_range(3) << THR_W);
    if ($urandom_range(9) == 0) hi = hi | ($urandom_range(3) << THR_W);
    if ($urandom_range(9) < 3) w  = -1;
    if ($urandom_range(9) < 3) h  = -1;
    if ($urandom_range(9) < 3) lo = -1;
    if ($urandom_range(9) < 3) hi = -1;
    apply_setup(w, h, lo, hi);
  endtask

  function automatic void pick_pixel(input texture_t tex, input int unsigned x,
                                     input int unsigned w, input int unsigned base,
                                     output logic [7:0] r, output logic [7:0] g,
                                     output logic [7:0] b);
    int unsigned lvl;
    case (tex)
      TEXTURE_BINARY: begin
        r = $urandom_range(1) ? 8'hFF : 8'h00;
        g = $urandom_range(1) ? 8'hFF : 8'h00;
        b = $urandom_range(1) ? 8'hFF : 8'h00;
      end
      TEXTURE_FLAT: begin
        // Nearly uniform: small gradients around the thresholds or none at all
        r = 8'(base + $urandom_range(5));
        g = 8'(base + $urandom_range(5));
        b = 8'(base + $urandom_range(5));
      end
      TEXTURE_STEP: begin
        lvl = (x < w / 2) ? $urandom_range(40) : $urandom_range(255, 200);
        r   = 8'(lvl);
        g   = 8'(lvl);
        b   = 8'(lvl ^ $urandom_range(7));
      end
      default: begin
        r = 8'($urandom_range(255));
        g = 8'($urandom_range(255));
        b = 8'($urandom_range(255));
      end
    endcase
  endfunction

  // One frame at the geometry the block holds now. A complete frame ends with
  // width+1 flush items, mostly pads with some stray pixels; a broken one
  // stops early and leaves the counters where they are.
  task automatic send_frame(input bit complete);
    int unsigned w, h, base, cut;
    texture_t    tex;
    logic [7:0]  r, g, b;
    w    = chk.eff_width();
    h    = chk.eff_height();
    tex  = texture_t'($urandom_range(3));
    base = $urandom_range(250);
    cut  = complete ? w * h : $urandom_range(w * h - 1, 1);
    for (int i = 0; i < cut; i++) begin
      pick_pixel(tex, i % w, w, base, r, g, b);
      send_pixel(r, g, b, $urandom_range(49) == 0);
    end
    if (complete) begin
      for (int i = 0; i <= w; i++) begin
        pick_pixel(TEXTURE_NOISE, 0, w, base, r, g, b);
        send_pixel(r, g, b, $urandom_range(9) != 0);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: take results, stall at random, and hold off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        chk.check_edge(edge_class, magnitude, frame_end);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // End the run when neither channel has moved a transfer for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d results still expected",
             WATCHDOG_LIMIT, chk.pending());
    $display("tb_top NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0]  r, g, b;
    int unsigned random_base;
    int unsigned done;
    pace_t       pace;

    chk         = new();
    pixels_sent = 0;
    reg_writes  = 0;
    hold_req    = 1'b0;
    tx_idle_pct = 12;
    rx_idle_pct = 59;
    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_index   <= REG_IMAGE_WIDTH;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    red         <= '0;
    green       <= '0;
    blue        <= '0;
    pad         <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Hold off until the line store clearing pass is over
    while (in_stall !== 1'b0) @(posedge clk);

    // Directed: smallest frame, every class made by threshold extremes.
    // Low 0 / high max: any nonzero magnitude is weak.
    apply_setup(3, 3, 0, 2047);
    send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1);  // pad inside the frame reads as gray 0
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
    // Flush, with real pixels past the frame acting as pads
    send_pixel(8'd0,   8'd0,   8'd0,   1'b1);
    send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
    send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
    send_pixel(8'd0,   8'd0,   8'd255, 1'b1);
    // Low max / high 0: any nonzero magnitude is strong; stale line data at the top
    apply_setup(-1, -1, 2047, 0);
    send_pixel(8'd255, 8'd0,   8'd0,   1'b0);
    send_pixel(8'd0,   8'd255, 8'd0,   1'b0);
    send_pixel(8'd0,   8'd0,   8'd255, 1'b0);
    send_pixel(8'd1,   8'd2,   8'd4,   1'b0);
    send_pixel(8'd128, 8'd64,  8'd32,  1'b0);
    send_pixel(8'd255, 8'd255, 8'd254, 1'b0);
    send_pixel(8'd170, 8'd85,  8'd0,   1'b0);
    send_pixel(8'd0,   8'd0,   8'd0,   1'b0);
    send_pixel(8'd85,  8'd170, 8'd255, 1'b0);
    repeat (4) send_pixel(8'd0, 8'd0, 8'd0, 1'b1);

    // Random frames in three pacing stretches
    random_base = pixels_sent;
    pace        = PACE_SLOW_SINK;
    while (pixels_sent - random_base < RANDOM_ITEMS) begin
      done = pixels_sent - random_base;
      if (pace == PACE_SLOW_SINK && done >= RANDOM_ITEMS / 3) begin
        pace        = PACE_SLOW_SOURCE;
        tx_idle_pct = 59;
        rx_idle_pct = 12;
      end else if (pace == PACE_SLOW_SOURCE && done >= 2 * RANDOM_ITEMS / 3) begin
        pace        = PACE_FULL;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // Hold the output back long enough that the block fills and stalls its input
        apply_setup(8, 4, 100, 300);
        hold_req = 1'b1;
        send_frame(1'b1);
      end
      if ($urandom_range(9) < 6) random_setup();
      send_frame($urandom_range(9) != 0);
    end

    // Widest line and tallest frame (both written above range), then shrink the
    // geometry mid-frame so the position is already past the new last pixel.
    apply_setup(2047, 8191, 40, 200);
    for (int i = 0; i < LINE_MAX + 20; i++) begin
      pick_pixel(TEXTURE_NOISE, 0, LINE_MAX, 0, r, g, b);
      send_pixel(r, g, b, 1'b0);
    end
    apply_setup(5, 0, -1, -1);
    send_frame(1'b1);
    send_frame(1'b1);

    settle();
    $display("run: %0d pixels, %0d register writes, %0d results (%0d strong, %0d weak, %0d none)",
             pixels_sent, reg_writes, chk.results_checked, chk.class_hits[CLASS_STRONG],
             chk.class_hits[CLASS_WEAK], chk.class_hits[CLASS_NONE]);
    $display("run: %0d frames closed, widths 3 to 1024, %0d mismatches",
             chk.frames_closed, chk.mismatches);
    if (chk.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
